// ===== rtl/ss_pkg.sv =====
package ss_pkg;

  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 64;
  localparam int LEN_BITS      = 4;
  localparam int OUT_POS_BITS  = 16;

  localparam logic [CFG_ADDR_BITS-1:0] ADDR_NEEDLE_BYTES  = 4'h0;
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_NEEDLE_LENGTH = 4'h8;

  localparam logic [7:0] NUL_CHAR = 8'h00;

  typedef struct packed {
    logic [CFG_DATA_BITS-1:0] chars;
    logic [LEN_BITS-1:0]      len;
  } needle_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_end;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

// ===== rtl/substring_search.sv =====
// Streaming substring search. The haystack enters one byte per item and
// ends with a zero byte; the needle (up to MAX_NEEDLE characters) and its
// length must be set by the user over the register port while the block is
// idle (unchecked). Each string yields exactly one result: found with the
// offset of the first match, or not found at the terminating zero byte. The
// block takes one byte per cycle while haystack_stall is low; a byte that
// gives a result passes through the two-entry input queue and the result
// register before the result port. The window compare is combinational.
module substring_search #(
  parameter int MAX_NEEDLE    = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ss_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [ss_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [ss_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                              pready,
  input  logic                              haystack_valid,
  output logic                              haystack_stall,
  input  logic [7:0]                        haystack_byte,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              found,
  output logic [ss_pkg::OUT_POS_BITS-1:0]   match_position
);

  ss_pkg::needle_t     needle;
  ss_pkg::queue_head_t head;
  logic                pop;

  ss_regs #(
    .MAX_NEEDLE (MAX_NEEDLE)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .needle  (needle)
  );

  ss_front u_front (
    .clk            (clk),
    .rst            (rst),
    .haystack_valid (haystack_valid),
    .haystack_stall (haystack_stall),
    .haystack_byte  (haystack_byte),
    .head           (head),
    .pop            (pop)
  );

  ss_back #(
    .MAX_NEEDLE    (MAX_NEEDLE),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .needle         (needle),
    .head           (head),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .found          (found),
    .match_position (match_position)
  );

endmodule

// ===== rtl/ss_regs.sv =====
module ss_regs #(
  parameter int MAX_NEEDLE = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ss_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [ss_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [ss_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                               pready,
  output ss_pkg::needle_t                    needle
);

  logic [ss_pkg::CFG_DATA_BITS-1:0] needle_bytes;
  logic [ss_pkg::LEN_BITS-1:0]      needle_length;
  logic                             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_bytes  <= '0;
      needle_length <= '0;
    end else if (wr_en) begin
      case (paddr)
        ss_pkg::ADDR_NEEDLE_BYTES: begin
          needle_bytes <= pwdata;
        end
        ss_pkg::ADDR_NEEDLE_LENGTH: begin
          needle_length <= pwdata[ss_pkg::LEN_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ss_pkg::ADDR_NEEDLE_BYTES:  prdata = needle_bytes;
      ss_pkg::ADDR_NEEDLE_LENGTH: prdata = ss_pkg::CFG_DATA_BITS'(needle_length);
      default:                    prdata = '0;
    endcase
  end

  // The needle ends at its first zero character, like a C string.
  always_comb begin
    logic [ss_pkg::LEN_BITS-1:0] clamped;
    logic [ss_pkg::LEN_BITS-1:0] eff;
    clamped = (needle_length > ss_pkg::LEN_BITS'(MAX_NEEDLE)) ?
              ss_pkg::LEN_BITS'(MAX_NEEDLE) : needle_length;
    eff = clamped;
    for (int i = MAX_NEEDLE - 1; i >= 0; i--) begin
      if ((ss_pkg::LEN_BITS'(i) < clamped) && (needle_bytes[8*i +: 8] == ss_pkg::NUL_CHAR)) begin
        eff = ss_pkg::LEN_BITS'(i);
      end
    end
    needle.chars = needle_bytes;
    needle.len   = eff;
  end

endmodule

// ===== rtl/ss_front.sv =====
module ss_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                haystack_valid,
  output logic                haystack_stall,
  input  logic [7:0]          haystack_byte,
  output ss_pkg::queue_head_t head,
  input  logic                pop
);

  ss_pkg::item_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  logic          take;

  assign haystack_stall = (count == 2'd2);
  assign push           = haystack_valid && !haystack_stall;
  assign take           = pop && (count != 2'd0);

  assign head.valid = (count != 2'd0);
  assign head.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr].data   <= haystack_byte;
      entries[wr_ptr].is_end <= (haystack_byte == ss_pkg::NUL_CHAR);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !take) begin
        count <= count + 2'd1;
      end else if (take && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/ss_back.sv =====
module ss_back #(
  parameter int MAX_NEEDLE    = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ss_pkg::needle_t                   needle,
  input  ss_pkg::queue_head_t               head,
  output logic                              pop,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              found,
  output logic [ss_pkg::OUT_POS_BITS-1:0]   match_position
);

  localparam int WIN_DEPTH = (MAX_NEEDLE > 1) ? MAX_NEEDLE - 1 : 1;
  localparam int IDX_BITS  = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
  localparam int WIN_SLOTS = 2 ** IDX_BITS;
  localparam logic [POSITION_BITS-1:0] COUNT_MAX = '1;
  localparam logic [32:0] OUT_POS_MAX = 33'((2 ** ss_pkg::OUT_POS_BITS) - 1);

  logic [7:0]               recent [WIN_DEPTH];
  logic [POSITION_BITS-1:0] bytes_seen;
  logic                     result_given;

  logic [7:0]               win [WIN_SLOTS];
  logic                     is_match;
  logic [POSITION_BITS-1:0] start_pos;
  logic [32:0]              start_wide;
  logic [7:0]               c;
  logic                     is_end;
  logic                     gives_result;

  assign c      = head.item.data;
  assign is_end = head.item.is_end;
  assign pop    = head.valid && (!result_valid || !result_stall);

  assign gives_result = pop && !result_given &&
                        ((needle.len == '0) || is_end || is_match);

  // Slot 0 is the byte being looked at, slot k the byte k items older.
  always_comb begin
    for (int k = 0; k < WIN_SLOTS; k++) begin
      if (k == 0) begin
        win[k] = c;
      end else if (k < MAX_NEEDLE) begin
        win[k] = recent[k-1];
      end else begin
        win[k] = ss_pkg::NUL_CHAR;
      end
    end
  end

  always_comb begin
    logic [ss_pkg::LEN_BITS-1:0] age;
    logic                        chars_ok;
    chars_ok = 1'b1;
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      age = needle.len - 4'd1 - ss_pkg::LEN_BITS'(i);
      if ((ss_pkg::LEN_BITS'(i) < needle.len) &&
          (win[age[IDX_BITS-1:0]] != needle.chars[8*i +: 8])) begin
        chars_ok = 1'b0;
      end
    end
    is_match  = chars_ok &&
                (bytes_seen >= POSITION_BITS'(needle.len - 4'd1));
    start_pos = bytes_seen - POSITION_BITS'(needle.len - 4'd1);
    start_wide = 33'(start_pos);
  end

  always_ff @(posedge clk) begin
    if (pop && !result_given && (needle.len != '0) && !is_end) begin
      for (int k = WIN_DEPTH - 1; k > 0; k--) begin
        recent[k] <= recent[k-1];
      end
      recent[0] <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      bytes_seen   <= '0;
      result_given <= 1'b0;
    end else begin
      if (gives_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (pop) begin
        if (result_given) begin
          if (is_end) begin
            bytes_seen   <= '0;
            result_given <= 1'b0;
          end
        end else if (needle.len == '0) begin
          if (is_end) begin
            bytes_seen <= '0;
          end else begin
            result_given <= 1'b1;
          end
        end else if (is_end) begin
          bytes_seen <= '0;
        end else begin
          if (bytes_seen != COUNT_MAX) begin
            bytes_seen <= bytes_seen + POSITION_BITS'(1);
          end
          if (is_match) begin
            result_given <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !result_given) begin
      if (needle.len == '0) begin
        found          <= 1'b1;
        match_position <= '0;
      end else if (is_end) begin
        found          <= 1'b0;
        match_position <= '0;
      end else if (is_match) begin
        found          <= 1'b1;
        match_position <= (start_wide > OUT_POS_MAX) ? '1 :
                          start_wide[ss_pkg::OUT_POS_BITS-1:0];
      end
    end
  end

endmodule

// ===== rtl/ss_checker.sv =====
module ss_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             pready,
  input logic                             result_valid,
  input logic                             result_stall,
  input logic                             found,
  input logic [ss_pkg::OUT_POS_BITS-1:0]  match_position
);

  // A waiting result holds its fields until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(found) &&
                                     $stable(match_position))
    else $error("stalled result changed");

  // A string without a match reports offset zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !found |-> match_position == '0)
    else $error("not-found result with nonzero offset");

  // The register port never inserts wait states.
  a_no_wait: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("register port stalled");

  // A reset clears any pending result.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result present right after reset");

endmodule

bind substring_search ss_checker u_ss_checker (
  .clk            (clk),
  .rst            (rst),
  .pready         (pready),
  .result_valid   (result_valid),
  .result_stall   (result_stall),
  .found          (found),
  .match_position (match_position)
);

// ===== test/substring_search_checker.sv =====
module substring_search_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ss_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [ss_pkg::CFG_DATA_BITS-1:0] pwdata,
  input  logic                             pready,
  input  logic                             haystack_valid,
  input  logic                             haystack_stall,
  input  logic [7:0]                       haystack_byte,
  input  logic                             result_valid,
  input  logic                             result_stall,
  input  logic                             found,
  input  logic [ss_pkg::OUT_POS_BITS-1:0]  match_position,
  output int                               failures,
  output int                               pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NEEDLE_CHARS = 8;
  localparam int WINDOW_DEPTH = NEEDLE_CHARS - 1;

  typedef struct packed {
    logic                            found;
    logic [ss_pkg::OUT_POS_BITS-1:0] position;
  } search_result_t;

  logic [ss_pkg::CFG_DATA_BITS-1:0] needle_chars;
  logic [ss_pkg::LEN_BITS-1:0]      needle_len;
  logic [7:0]                       window [0:WINDOW_DEPTH-1];
  logic [15:0]                      bytes_seen;
  logic                             result_given;
  search_result_t                   expected_q [$];

  function automatic logic [7:0] needle_char(input int unsigned i);
    return needle_chars[8*i +: 8];
  endfunction

  // The needle stops at its first zero character, like a C string.
  function automatic int unsigned usable_length();
    int unsigned n;
    n = (needle_len > NEEDLE_CHARS) ? NEEDLE_CHARS : needle_len;
    for (int unsigned i = 0; i < n; i++)
      if (needle_char(i) == ss_pkg::NUL_CHAR) return i;
    return n;
  endfunction

  function automatic void clear_string();
    for (int i = 0; i < WINDOW_DEPTH; i++) window[i] = ss_pkg::NUL_CHAR;
    bytes_seen = '0;
    result_given = 1'b0;
  endfunction

  function automatic void apply_byte(input logic [7:0] c);
    int unsigned len;
    int unsigned age;
    logic [7:0] b;
    logic hit;
    logic [15:0] start;
    len = usable_length();
    if (result_given) begin
      if (c == ss_pkg::NUL_CHAR) clear_string();
    end else if (len == 0) begin
      expected_q.push_back('{1'b1, '0});
      if (c == ss_pkg::NUL_CHAR) clear_string();
      else result_given = 1'b1;
    end else if (c == ss_pkg::NUL_CHAR) begin
      expected_q.push_back('{1'b0, '0});
      clear_string();
    end else begin
      hit = (bytes_seen >= len - 1);
      // Needle character i lines up with the byte that came len-1-i items ago.
      for (int unsigned i = 0; i < len; i++) begin
        age = len - 1 - i;
        b = (age == 0) ? c : window[age-1];
        if (b != needle_char(i)) hit = 1'b0;
      end
      start = bytes_seen - 16'(len - 1);
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = c;
      if (bytes_seen != '1) bytes_seen++;
      if (hit) begin
        result_given = 1'b1;
        expected_q.push_back('{1'b1, start});
      end
    end
  endfunction

  function automatic void check_result();
    search_result_t want;
    if (expected_q.size() == 0) begin
      failures++;
      $display("%0t: unexpected result: expected none, actual found=%0b position=%0d",
               $time, found, match_position);
    end else begin
      want = expected_q.pop_front();
      if (found !== want.found) begin
        failures++;
        $display("%0t: found mismatch: expected %0b, actual %0b",
                 $time, want.found, found);
      end
      if (match_position !== want.position) begin
        failures++;
        $display("%0t: match_position mismatch: expected %0d, actual %0d",
                 $time, want.position, match_position);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      needle_chars = '0;
      needle_len = '0;
      clear_string();
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ss_pkg::ADDR_NEEDLE_BYTES:  needle_chars = pwdata;
          ss_pkg::ADDR_NEEDLE_LENGTH: needle_len = pwdata[ss_pkg::LEN_BITS-1:0];
          default: ;
        endcase
      end
      // Results come from older items, so compare before this edge's item is added.
      if (result_valid && !result_stall) check_result();
      if (haystack_valid && !haystack_stall) apply_byte(haystack_byte);
    end
    pending_results = expected_q.size();
  end

endmodule

// ===== test/substring_search_tb.sv =====
module substring_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [ss_pkg::CFG_ADDR_BITS-1:0] paddr = '0;
  logic [ss_pkg::CFG_DATA_BITS-1:0] pwdata = '0;
  logic [ss_pkg::CFG_DATA_BITS-1:0] prdata;
  logic                             pready;
  logic                             haystack_valid = 1'b0;
  logic                             haystack_stall;
  logic [7:0]                       haystack_byte = '0;
  logic                             result_valid;
  logic                             result_stall = 1'b0;
  logic                             found;
  logic [ss_pkg::OUT_POS_BITS-1:0]  match_position;

  int failures;
  int pending_results;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  logic hold_req = 1'b0;

  logic [ss_pkg::CFG_DATA_BITS-1:0] cur_chars = '0;
  logic [ss_pkg::LEN_BITS-1:0]      cur_len = '0;

  substring_search u_dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .haystack_valid (haystack_valid),
    .haystack_stall (haystack_stall),
    .haystack_byte  (haystack_byte),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .found          (found),
    .match_position (match_position)
  );

  substring_search_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .haystack_valid  (haystack_valid),
    .haystack_stall  (haystack_stall),
    .haystack_byte   (haystack_byte),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .found           (found),
    .match_position  (match_position),
    .failures        (failures),
    .pending_results (pending_results)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || psel || (haystack_valid && !haystack_stall) ||
        (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, or one long hold-off when asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic write_reg(input logic [ss_pkg::CFG_ADDR_BITS-1:0] addr,
                           input logic [ss_pkg::CFG_DATA_BITS-1:0] data);
    logic rdy;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      @(posedge clk);
    end while (!rdy);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_needle(input logic [ss_pkg::CFG_DATA_BITS-1:0] chars,
                            input logic [ss_pkg::LEN_BITS-1:0] len);
    cur_chars = chars;
    cur_len = len;
    write_reg(ss_pkg::ADDR_NEEDLE_BYTES, chars);
    write_reg(ss_pkg::ADDR_NEEDLE_LENGTH, ss_pkg::CFG_DATA_BITS'(len));
  endtask

  task automatic send_byte(input logic [7:0] b);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      haystack_valid <= 1'b0;
      @(posedge clk);
    end
    haystack_valid <= 1'b1;
    haystack_byte <= b;
    do begin
      @(negedge clk);
      taken = !haystack_stall;
      @(posedge clk);
    end while (!taken);
    items_sent++;
  endtask

  // Waits until every expected result is in, then gives the pipeline time to settle
  // on items that produce no result.
  task automatic drain();
    haystack_valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    int unsigned idx;
    logic [7:0] c;
    case ($urandom_range(9))
      0: return 8'($urandom_range(1, 255));
      1, 2, 3: return 8'h61 + 8'($urandom_range(2));
      default: begin
        idx = $urandom_range(7);
        c = cur_chars[8*idx +: 8];
        return (c == ss_pkg::NUL_CHAR) ? 8'h61 : c;
      end
    endcase
  endfunction

  task automatic new_needle();
    logic [ss_pkg::CFG_DATA_BITS-1:0] chars;
    logic [ss_pkg::LEN_BITS-1:0] len;
    case ($urandom_range(19))
      0: chars = '1;
      1: chars = '0;
      default: begin
        for (int k = 0; k < 8; k++)
          chars[8*k +: 8] = ($urandom_range(9) < 7) ? 8'h61 + 8'($urandom_range(2))
                                                    : 8'($urandom_range(255));
      end
    endcase
    case ($urandom_range(9))
      0: len = '0;
      1: len = ss_pkg::LEN_BITS'($urandom_range(5, 8));
      2: len = ss_pkg::LEN_BITS'($urandom_range(9, 15));
      default: len = ss_pkg::LEN_BITS'($urandom_range(1, 4));
    endcase
    set_needle(chars, len);
  endtask

  // A string of needle-like characters, often with the needle planted in it.
  // A few are left unterminated and run into the next one.
  task automatic send_string();
    int unsigned body_len;
    int unsigned plant_at;
    int unsigned n;
    body_len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    plant_at = ($urandom_range(9) < 4) ? $urandom_range(0, body_len) : body_len + 1;
    n = (cur_len > 8) ? 8 : cur_len;
    for (int unsigned k = 0; k <= body_len; k++) begin
      if (k == plant_at) begin
        for (int unsigned j = 0; j < n && cur_chars[8*j +: 8] != ss_pkg::NUL_CHAR; j++)
          send_byte(cur_chars[8*j +: 8]);
      end
      if (k < body_len) send_byte(pick_char());
    end
    if ($urandom_range(9) != 0) send_byte(ss_pkg::NUL_CHAR);
  endtask

  task automatic run_phase(input int n_items);
    int target;
    target = items_sent + n_items;
    drain();
    new_needle();
    while (items_sent < target) begin
      // Sometimes the needle changes between strings, which is mid-string when the last one was left unterminated.
      if ($urandom_range(15) == 0) begin
        drain();
        new_needle();
      end
      send_string();
    end
    drain();
  endtask

  task automatic directed_checks();
    set_needle(64'h6261, 4'd2);
    send_byte(8'h78); send_byte(8'h61); send_byte(8'h62); send_byte(ss_pkg::NUL_CHAR);
    send_byte(8'h61); send_byte(ss_pkg::NUL_CHAR);
    send_byte(ss_pkg::NUL_CHAR);
    drain();
    // Empty needle, both on a terminator and on an ordinary first byte.
    set_needle(64'h6261, 4'd0);
    send_byte(ss_pkg::NUL_CHAR);
    send_byte(8'h71); send_byte(ss_pkg::NUL_CHAR);
    drain();
    // Length above the window is cut to eight characters.
    set_needle('1, 4'd15);
    repeat (8) send_byte(8'hFF);
    send_byte(ss_pkg::NUL_CHAR);
    drain();
    // A zero inside the needle shortens it to one character.
    set_needle(64'h630061, 4'd3);
    send_byte(8'h7A); send_byte(8'h7A); send_byte(8'h61); send_byte(ss_pkg::NUL_CHAR);
    drain();
    // New needle mid-string is compared against bytes already in the window.
    set_needle(64'h7A7A, 4'd2);
    send_byte(8'h61); send_byte(8'h62);
    drain();
    set_needle(64'h6362, 4'd2);
    send_byte(8'h63); send_byte(ss_pkg::NUL_CHAR);
    drain();
  endtask

  task automatic fill_and_hold();
    set_needle(64'h61, 4'd1);
    hold_req = 1'b1;
    repeat (20) begin
      send_byte(8'h61);
      send_byte(ss_pkg::NUL_CHAR);
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_checks();

    send_idle_pct = 10;
    recv_stall_pct = 50;
    run_phase(320);

    send_idle_pct = 50;
    recv_stall_pct = 10;
    run_phase(320);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    fill_and_hold();
    run_phase(270);

    repeat (20) @(posedge clk);
    @(negedge clk);
    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
